// ===== hdl/sampson_inlier_classifier_assert.svh =====
// Assertion macros for the Sampson inlier classifier.
`ifndef SAMPSON_INLIER_CLASSIFIER_ASSERT_SVH
`define SAMPSON_INLIER_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define SIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SIC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SIC_ASSERT(lbl, prop, msg)
`define SIC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/sic_pkg.sv =====
// Types, constants and microprogram of the Sampson inlier classifier.
`default_nettype none

package sic_pkg;

  localparam int unsigned MATCH_INDEX_BITS = 16;
  localparam logic [15:0] IDX_MASK = 16'((33'd1 << MATCH_INDEX_BITS) - 33'd1);

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned STEP_W  = 6;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [31:0] THR_RESET = 32'd38;

  // Register index, taken from paddr[4:3]
  localparam logic [1:0] REG_F_ROW0 = 2'd0;
  localparam logic [1:0] REG_F_ROW1 = 2'd1;
  localparam logic [1:0] REG_F_ROW2 = 2'd2;
  localparam logic [1:0] REG_THR    = 2'd3;

  // F entry select: {row, col}
  localparam logic [3:0] F00 = 4'b0000;
  localparam logic [3:0] F01 = 4'b0001;
  localparam logic [3:0] F02 = 4'b0010;
  localparam logic [3:0] F10 = 4'b0100;
  localparam logic [3:0] F11 = 4'b0101;
  localparam logic [3:0] F12 = 4'b0110;
  localparam logic [3:0] F20 = 4'b1000;
  localparam logic [3:0] F21 = 4'b1001;
  localparam logic [3:0] F22 = 4'b1010;

  localparam logic [STEP_W-1:0] LOOP_STEP = 6'd43;
  localparam logic [STEP_W-1:0] END_STEP  = 6'd44;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [2:0] {
    A_F,
    A_X2,
    A_Y2,
    A_HI,
    A_LO
  } a_sel_e;

  typedef enum logic [3:0] {
    B_X1, B_Y1, B_X2, B_Y2,
    B_X1S, B_Y1S, B_X2S, B_Y2S,
    B_K12, B_K24,
    B_QXX, B_QXY, B_QYX, B_QYY,
    B_HI, B_LO
  } b_sel_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LD,
    OP_ADD,
    OP_SQ_HH_LD,
    OP_SQ_HH,
    OP_SQ_HL,
    OP_SQ_LL
  } op_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_QXX, WR_QXY, WR_QYX, WR_QYY,
    WR_L0, WR_L1, WR_M0, WR_M1,
    WR_E,
    WR_DEN
  } wr_e;

  typedef enum logic [2:0] {
    MAG_NONE,
    MAG_L0, MAG_L1, MAG_M0, MAG_M1,
    MAG_E
  } mag_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_CHK,
    SEQ_LOOP,
    SEQ_END
  } seq_e;

  typedef struct packed {
    a_sel_e            a_sel;
    logic [3:0]        f_sel;
    b_sel_e            b_sel;
    op_e               op;
    wr_e               wr;
    mag_e              mag;
    seq_e              seq;
    logic [STEP_W-1:0] tgt;
  } ucode_t;

  localparam ucode_t UC_NOP = '{a_sel: A_F, f_sel: F00, b_sel: B_X1, op: OP_NONE,
                                wr: WR_NONE, mag: MAG_NONE, seq: SEQ_NEXT, tgt: '0};

  function automatic ucode_t uw(input a_sel_e a, input logic [3:0] f, input b_sel_e b,
                                input op_e op, input wr_e wr, input mag_e mg,
                                input seq_e sq, input logic [STEP_W-1:0] tgt);
    ucode_t w;
    w.a_sel = a;
    w.f_sel = f;
    w.b_sel = b;
    w.op    = op;
    w.wr    = wr;
    w.mag   = mg;
    w.seq   = sq;
    w.tgt   = tgt;
    return w;
  endfunction

  // Each product is registered in prod_q, accumulated from there, and the sum stored from acc_q.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      // cross products of the two points
      6'd0:  w = uw(A_X2, F00, B_X1,  OP_NONE,     WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd1:  w = uw(A_X2, F00, B_Y1,  OP_LD,       WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd2:  w = uw(A_Y2, F00, B_X1,  OP_LD,       WR_QXX,  MAG_NONE, SEQ_NEXT, '0);
      6'd3:  w = uw(A_Y2, F00, B_Y1,  OP_LD,       WR_QXY,  MAG_NONE, SEQ_NEXT, '0);
      // l0, l1
      6'd4:  w = uw(A_F,  F00, B_X1,  OP_LD,       WR_QYX,  MAG_NONE, SEQ_NEXT, '0);
      6'd5:  w = uw(A_F,  F01, B_Y1,  OP_LD,       WR_QYY,  MAG_NONE, SEQ_NEXT, '0);
      6'd6:  w = uw(A_F,  F02, B_K12, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd7:  w = uw(A_F,  F10, B_X1,  OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd8:  w = uw(A_F,  F11, B_Y1,  OP_LD,       WR_L0,   MAG_NONE, SEQ_NEXT, '0);
      6'd9:  w = uw(A_F,  F12, B_K12, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      // m0, m1
      6'd10: w = uw(A_F,  F00, B_X2,  OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd11: w = uw(A_F,  F10, B_Y2,  OP_LD,       WR_L1,   MAG_NONE, SEQ_NEXT, '0);
      6'd12: w = uw(A_F,  F20, B_K12, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd13: w = uw(A_F,  F01, B_X2,  OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd14: w = uw(A_F,  F11, B_Y2,  OP_LD,       WR_M0,   MAG_NONE, SEQ_NEXT, '0);
      6'd15: w = uw(A_F,  F21, B_K12, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      // residual as the sum of F(r,c) * p2(r) * p1(c)
      6'd16: w = uw(A_F,  F00, B_QXX, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd17: w = uw(A_F,  F01, B_QXY, OP_LD,       WR_M1,   MAG_NONE, SEQ_NEXT, '0);
      6'd18: w = uw(A_F,  F02, B_X2S, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd19: w = uw(A_F,  F10, B_QYX, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd20: w = uw(A_F,  F11, B_QYY, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd21: w = uw(A_F,  F12, B_Y2S, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd22: w = uw(A_F,  F20, B_X1S, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd23: w = uw(A_F,  F21, B_Y1S, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd24: w = uw(A_F,  F22, B_K24, OP_ADD,      WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd25: w = uw(A_F,  F00, B_X1,  OP_ADD,      WR_NONE, MAG_L0,   SEQ_NEXT, '0);
      // squares in 25-bit halves: denominator first, then residual
      6'd26: w = uw(A_HI, F00, B_HI,  OP_NONE,     WR_E,    MAG_NONE, SEQ_NEXT, '0);
      6'd27: w = uw(A_HI, F00, B_LO,  OP_SQ_HH_LD, WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd28: w = uw(A_LO, F00, B_LO,  OP_SQ_HL,    WR_NONE, MAG_L1,   SEQ_NEXT, '0);
      6'd29: w = uw(A_HI, F00, B_HI,  OP_SQ_LL,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd30: w = uw(A_HI, F00, B_LO,  OP_SQ_HH,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd31: w = uw(A_LO, F00, B_LO,  OP_SQ_HL,    WR_NONE, MAG_M0,   SEQ_NEXT, '0);
      6'd32: w = uw(A_HI, F00, B_HI,  OP_SQ_LL,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd33: w = uw(A_HI, F00, B_LO,  OP_SQ_HH,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd34: w = uw(A_LO, F00, B_LO,  OP_SQ_HL,    WR_NONE, MAG_M1,   SEQ_NEXT, '0);
      6'd35: w = uw(A_HI, F00, B_HI,  OP_SQ_LL,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd36: w = uw(A_HI, F00, B_LO,  OP_SQ_HH,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd37: w = uw(A_LO, F00, B_LO,  OP_SQ_HL,    WR_NONE, MAG_E,    SEQ_NEXT, '0);
      6'd38: w = uw(A_HI, F00, B_HI,  OP_SQ_LL,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd39: w = uw(A_HI, F00, B_LO,  OP_SQ_HH_LD, WR_DEN,  MAG_NONE, SEQ_NEXT, '0);
      6'd40: w = uw(A_LO, F00, B_LO,  OP_SQ_HL,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      6'd41: w = uw(A_F,  F00, B_X1,  OP_SQ_LL,    WR_NONE, MAG_NONE, SEQ_NEXT, '0);
      // range check, division, result
      6'd42: w = uw(A_F,  F00, B_X1,  OP_NONE,     WR_NONE, MAG_NONE, SEQ_CHK,  END_STEP);
      6'd43: w = uw(A_F,  F00, B_X1,  OP_NONE,     WR_NONE, MAG_NONE, SEQ_LOOP, LOOP_STEP);
      6'd44: w = uw(A_F,  F00, B_X1,  OP_NONE,     WR_NONE, MAG_NONE, SEQ_END,  '0);
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sampson_inlier_classifier.sv =====
// Sampson-distance inlier classifier: microcoded datapath, APB registers and handshakes.
//
// Scores one correspondence (x1,y1)-(x2,y2), Q4.12, against the fundamental matrix F (Q2.16
// entries, three 54-bit row registers at byte addresses 0, 8, 16; threshold_sq at 24, all on
// a 64-bit APB port) and returns the Sampson distance in unsigned Q8.24, truncated and
// saturated to all ones, an inlier flag (distance below threshold_sq, never on a zero
// denominator) and the running inlier count, which clears after the word marked last. An
// item is scored by a 45-step microprogram that drives one shared 26x33 signed multiplier
// through 40 products, followed by a 32-step restoring divider, one quotient bit per cycle,
// which is skipped when the denominator is zero or the quotient overflows. Input is taken
// one item at a time; the result register frees the sequencer while a finished word waits
// on the output side.
`default_nettype none
`include "sampson_inlier_classifier_assert.svh"

module sampson_inlier_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          x1_i,
  input  logic signed [15:0]          y1_i,
  input  logic signed [15:0]          x2_i,
  input  logic signed [15:0]          y2_i,
  input  logic        [15:0]          match_index_i,
  input  logic                        last_match_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic        [15:0]          match_id_o,
  output logic                        inlier_o,
  output logic        [31:0]          distance_o,
  output logic        [16:0]          inlier_count_o,
  output logic                        last_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sic_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import sic_pkg::*;

  // configuration registers
  logic [53:0] f_row0_q, f_row1_q, f_row2_q;
  logic [31:0] thr_q;
  logic        cfg_wr;

  // sequencer
  state_e            state_q, state_d;
  logic [STEP_W-1:0] upc_q, upc_d;
  logic              run;
  logic              in_acc;
  logic              res_load;
  ucode_t            uc;

  // item registers
  logic signed [15:0] x1_q, y1_q, x2_q, y2_q;
  logic        [15:0] idx_q;
  logic               lastm_q;

  // datapath
  logic signed [25:0] a_op;
  logic signed [32:0] b_op;
  logic signed [17:0] fval;
  logic        [53:0] frow;
  logic signed [58:0] prod_d, prod_q;
  logic signed [51:0] acc_q;
  logic        [99:0] sacc_q;
  logic signed [31:0] qxx_q, qxy_q, qyx_q, qyy_q;
  logic signed [34:0] l0_q, l1_q, m0_q, m1_q;
  logic signed [50:0] e_q;
  logic        [69:0] den_q;
  logic signed [50:0] msel, mabs;
  logic        [49:0] mag_q;
  logic        [24:0] mhi, mlo;

  // divider
  logic [99:0]  rem_q;
  logic [100:0] dv_q;
  logic [31:0]  quo_q;
  logic [4:0]   cnt_q;
  logic         sat_q, sat_d;
  logic         div_ge;
  logic         div_step;

  // result
  logic [31:0] dist_val;
  logic        inl;
  logic [16:0] icnt_q, icnt_inc, icnt_new;
  logic        out_valid_q;
  logic [15:0] match_id_q;
  logic        inlier_q;
  logic [31:0] dist_q;
  logic [16:0] cnt_out_q;
  logic        last_q;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_row0_q <= '0;
      f_row1_q <= '0;
      f_row2_q <= '0;
      thr_q    <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_F_ROW0: f_row0_q <= pwdata[53:0];
        REG_F_ROW1: f_row1_q <= pwdata[53:0];
        REG_F_ROW2: f_row2_q <= pwdata[53:0];
        REG_THR:    thr_q    <= pwdata[31:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_F_ROW0: prdata = 64'(f_row0_q);
      REG_F_ROW1: prdata = 64'(f_row1_q);
      REG_F_ROW2: prdata = 64'(f_row2_q);
      REG_THR:    prdata = 64'(thr_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  assign in_acc   = in_valid_i && !in_stall_o;
  assign uc       = run ? ucode_rom(upc_q) : UC_NOP;
  assign div_step = run && (uc.seq == SEQ_LOOP);
  assign res_load = run && (uc.seq == SEQ_END) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (res_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    run = 1'b0;
    unique case (state_q)
      ST_IDLE: run = 1'b0;
      ST_RUN:  run = 1'b1;
      default: run = 1'b0;
    endcase
  end

  assign in_stall_o = run;

  always_comb begin
    upc_d = upc_q;
    if (!run) begin
      upc_d = '0;
    end else begin
      unique case (uc.seq)
        SEQ_NEXT: upc_d = upc_q + 1'b1;
        SEQ_CHK:  upc_d = sat_d ? uc.tgt : upc_q + 1'b1;
        // stay on the divide step until the last quotient bit
        SEQ_LOOP: upc_d = (cnt_q != '0) ? uc.tgt : upc_q + 1'b1;
        SEQ_END:  upc_d = res_load ? '0 : upc_q;
        default:  upc_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upc_q   <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x1_q    <= x1_i;
      y1_q    <= y1_i;
      x2_q    <= x2_i;
      y2_q    <= y2_i;
      idx_q   <= match_index_i & IDX_MASK;
      lastm_q <= last_match_i;
    end
  end

  // ---------------------------------------------------------------- multiplier
  always_comb begin
    unique case (uc.f_sel[3:2])
      2'd0:    frow = f_row0_q;
      2'd1:    frow = f_row1_q;
      2'd2:    frow = f_row2_q;
      default: frow = '0;
    endcase
    unique case (uc.f_sel[1:0])
      2'd0:    fval = frow[17:0];
      2'd1:    fval = frow[35:18];
      2'd2:    fval = frow[53:36];
      default: fval = '0;
    endcase
  end

  assign mhi = mag_q[49:25];
  assign mlo = mag_q[24:0];

  always_comb begin
    unique case (uc.a_sel)
      A_F:     a_op = 26'(fval);
      A_X2:    a_op = 26'(x2_q);
      A_Y2:    a_op = 26'(y2_q);
      A_HI:    a_op = {1'b0, mhi};
      A_LO:    a_op = {1'b0, mlo};
      default: a_op = '0;
    endcase
  end

  always_comb begin
    unique case (uc.b_sel)
      B_X1:    b_op = 33'(x1_q);
      B_Y1:    b_op = 33'(y1_q);
      B_X2:    b_op = 33'(x2_q);
      B_Y2:    b_op = 33'(y2_q);
      B_X1S:   b_op = 33'(x1_q) <<< 12;
      B_Y1S:   b_op = 33'(y1_q) <<< 12;
      B_X2S:   b_op = 33'(x2_q) <<< 12;
      B_Y2S:   b_op = 33'(y2_q) <<< 12;
      B_K12:   b_op = 33'sd4096;
      B_K24:   b_op = 33'sd16777216;
      B_QXX:   b_op = 33'(qxx_q);
      B_QXY:   b_op = 33'(qxy_q);
      B_QYX:   b_op = 33'(qyx_q);
      B_QYY:   b_op = 33'(qyy_q);
      B_HI:    b_op = {8'd0, mhi};
      B_LO:    b_op = {8'd0, mlo};
      default: b_op = '0;
    endcase
  end

  assign prod_d = 59'(a_op) * 59'(b_op);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------- accumulators
  always_ff @(posedge clk_i) begin
    unique case (uc.op)
      OP_NONE:     ;
      OP_LD:       acc_q <= prod_q[51:0];
      OP_ADD:      acc_q <= acc_q + prod_q[51:0];
      OP_SQ_HH_LD: sacc_q <= {prod_q[49:0], 50'd0};
      OP_SQ_HH:    sacc_q <= sacc_q + {prod_q[49:0], 50'd0};
      // cross term counts twice: shift by 26, not 25
      OP_SQ_HL:    sacc_q <= sacc_q + (100'(prod_q[49:0]) << 26);
      OP_SQ_LL:    sacc_q <= sacc_q + 100'(prod_q[49:0]);
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (uc.wr)
      WR_NONE: ;
      WR_QXX:  qxx_q <= acc_q[31:0];
      WR_QXY:  qxy_q <= acc_q[31:0];
      WR_QYX:  qyx_q <= acc_q[31:0];
      WR_QYY:  qyy_q <= acc_q[31:0];
      WR_L0:   l0_q  <= acc_q[34:0];
      WR_L1:   l1_q  <= acc_q[34:0];
      WR_M0:   m0_q  <= acc_q[34:0];
      WR_M1:   m1_q  <= acc_q[34:0];
      WR_E:    e_q   <= acc_q[50:0];
      WR_DEN:  den_q <= sacc_q[69:0];
      default: ;
    endcase
  end

  always_comb begin
    unique case (uc.mag)
      MAG_L0:  msel = 51'(l0_q);
      MAG_L1:  msel = 51'(l1_q);
      MAG_M0:  msel = 51'(m0_q);
      MAG_M1:  msel = 51'(m1_q);
      MAG_E:   msel = e_q;
      default: msel = '0;
    endcase
    mabs = msel[50] ? -msel : msel;
  end

  always_ff @(posedge clk_i) begin
    if (uc.mag != MAG_NONE) begin
      mag_q <= mabs[49:0];
    end
  end

  // ---------------------------------------------------------------- divider
  // saturate on a zero denominator or when the quotient needs more than 32 bits
  assign sat_d  = (den_q == '0) || ({2'b00, sacc_q} >= {den_q, 32'd0});
  assign div_ge = {1'b0, rem_q} >= dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (run && (uc.seq == SEQ_CHK)) begin
      cnt_q <= 5'd31;
    end else if (div_step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && (uc.seq == SEQ_CHK)) begin
      sat_q <= sat_d;
      rem_q <= sacc_q;
      dv_q  <= {den_q, 31'd0};
      quo_q <= '0;
    end else if (div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dv_q[99:0];
      end
      dv_q  <= dv_q >> 1;
      quo_q <= {quo_q[30:0], div_ge};
    end
  end

  // ---------------------------------------------------------------- result
  assign dist_val = sat_q ? '1 : quo_q;
  assign inl      = !sat_q && (dist_val < thr_q);
  assign icnt_inc = (icnt_q != COUNT_MAX) ? icnt_q + 17'd1 : icnt_q;
  assign icnt_new = inl ? icnt_inc : icnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        // drop the count once the last match of the list has been scored
        icnt_q      <= lastm_q ? '0 : icnt_new;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      match_id_q <= idx_q;
      inlier_q   <= inl;
      dist_q     <= dist_val;
      cnt_out_q  <= icnt_new;
      last_q     <= lastm_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_id_o     = match_id_q;
  assign inlier_o       = inlier_q;
  assign distance_o     = dist_q;
  assign inlier_count_o = cnt_out_q;
  assign last_o         = last_q;

  // ---------------------------------------------------------------- checks
  `SIC_ASSERT(a_inlier_below_thr, out_valid_o && inlier_o |-> distance_o < thr_q, "inlier word at or above threshold")
  `SIC_ASSERT(a_div_count, (div_step && (cnt_q != '0)) |=> (cnt_q == $past(cnt_q) - 5'd1), "divide step count did not advance")
  `SIC_ASSERT(a_accept_starts, in_acc |=> (state_q == ST_RUN && upc_q == '0), "accepted word did not start the program")
  `SIC_ASSERT(a_last_clears, (res_load && lastm_q) |=> (icnt_q == '0), "count not cleared after last match")
  `SIC_ASSERT_NEVER(a_step_range, run && (upc_q > END_STEP), "step counter past end of program")

endmodule

`default_nettype wire

// ===== dv/sampson_inlier_classifier_tb.sv =====
// Self-checking testbench for the Sampson inlier classifier: directed and random matches.
`timescale 1ns / 100ps

module sampson_inlier_classifier_tb;
  import sic_pkg::*;

  typedef struct {
    logic signed [15:0] x1, y1, x2, y2;
    logic        [15:0] idx;
    logic               last;
  } match_t;

  typedef struct {
    logic [15:0] match_id;
    logic        inlier;
    logic [31:0] distance;
    logic [16:0] count;
    logic        last;
  } score_t;

  typedef enum {LINE_NONE, LINE_HORIZ, LINE_VERT} line_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] x1 = '0, y1 = '0, x2 = '0, y2 = '0;
  logic        [15:0] match_index = '0;
  logic               last_match = 1'b0;

  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [15:0] match_id_o;
  logic        inlier_o;
  logic [31:0] distance_o;
  logic [16:0] inlier_count_o;
  logic        last_o;

  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  // scoreboard state and a copy of the block's registers
  match_t      pend_q[$];
  score_t      score_q[$];
  match_t      cur_match;
  logic [53:0] f_model[3] = '{default: '0};
  logic [31:0] thr_model = THR_RESET;
  logic [16:0] inlier_tally = '0;
  int          n_errors = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  sampson_inlier_classifier i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .x1_i           (x1),
    .y1_i           (y1),
    .x2_i           (x2),
    .y2_i           (y2),
    .match_index_i  (match_index),
    .last_match_i   (last_match),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .match_id_o     (match_id_o),
    .inlier_o       (inlier_o),
    .distance_o     (distance_o),
    .inlier_count_o (inlier_count_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [127:0] square_mag(input logic signed [63:0] v);
    logic [63:0]  m;
    logic [127:0] w;
    m = (v < 0) ? -v : v;
    w = m;
    return w * w;
  endfunction

  // Score one match against the current F and threshold; advance the inlier tally.
  function automatic score_t score_match(input match_t m);
    logic signed [63:0]  fm[3][3];
    logic signed [17:0]  ent;
    logic signed [63:0]  px1, py1, px2, py2, l0, l1, l2, m0, m1, e;
    logic        [127:0] num, den;
    score_t              s;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ent = f_model[r][18*c +: 18];
        fm[r][c] = ent;
      end
    end
    px1 = m.x1;
    py1 = m.y1;
    px2 = m.x2;
    py2 = m.y2;
    l0 = px1 * fm[0][0] + py1 * fm[0][1] + fm[0][2] * 4096;
    l1 = px1 * fm[1][0] + py1 * fm[1][1] + fm[1][2] * 4096;
    l2 = px1 * fm[2][0] + py1 * fm[2][1] + fm[2][2] * 4096;
    m0 = px2 * fm[0][0] + py2 * fm[1][0] + fm[2][0] * 4096;
    m1 = px2 * fm[0][1] + py2 * fm[1][1] + fm[2][1] * 4096;
    e  = px2 * l0 + py2 * l1 + l2 * 4096;
    num = square_mag(e);
    den = square_mag(l0) + square_mag(l1) + square_mag(m0) + square_mag(m1);
    s.inlier = 1'b0;
    if (den == '0) begin
      s.distance = '1;
    end else begin
      // saturate when the quotient does not fit in 32 bits
      if (num >= (den << 32)) s.distance = '1;
      else s.distance = 32'(num / den);
      s.inlier = s.distance < thr_model;
    end
    if (s.inlier && inlier_tally != COUNT_MAX) inlier_tally++;
    s.match_id = m.idx & IDX_MASK;
    s.count    = inlier_tally;
    s.last     = m.last;
    if (m.last) inlier_tally = '0;
    return s;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1;
  endfunction

  function automatic match_t mk_match(input int ax1, input int ay1, input int ax2,
                                      input int ay2, input int idx, input bit last);
    match_t m;
    m.x1   = 16'(ax1);
    m.y1   = 16'(ay1);
    m.x2   = 16'(ax2);
    m.y2   = 16'(ay2);
    m.idx  = 16'(idx);
    m.last = last;
    return m;
  endfunction

  // Mostly points on the epipolar line of the given kind, with up to 12 LSBs of noise.
  function automatic match_t random_match(input line_e line);
    match_t m;
    int     noise;
    m = mk_match($urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 9) == 0);
    noise = int'($urandom_range(0, 24)) - 12;
    if ($urandom_range(0, 4) != 0) begin
      if (line == LINE_HORIZ) m.y2 = m.y1 + 16'(noise);
      else if (line == LINE_VERT) m.x2 = m.x1 + 16'(noise);
    end
    return m;
  endfunction

  function automatic logic [63:0] pack_row(input int a, input int b, input int c);
    return {10'd0, 18'(c), 18'(b), 18'(a)};
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 128)) - 64;
  endfunction

  function automatic int extreme_entry();
    return $urandom_range(0, 1) ? 131071 : -131072;
  endfunction

  // Append a match to the pending words.
  task automatic add_pending(input match_t m);
    pend_q.insert(pend_q.size(), m);
  endtask

  // Write a register over APB, mirror it, and read it back.
  task automatic set_reg(input logic [1:0] ridx, input logic [63:0] val);
    logic [63:0] held;
    logic [63:0] got;
    held = (ridx == REG_THR) ? {32'd0, val[31:0]} : {10'd0, val[53:0]};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (ridx == REG_THR) thr_model = held[31:0];
    else f_model[ridx] = held[53:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== held) begin
      $error("register %0d readback: expected %h, got %h", ridx, held, got);
      n_errors++;
    end
  endtask

  task automatic set_f(input logic [63:0] r0, input logic [63:0] r1, input logic [63:0] r2);
    set_reg(REG_F_ROW0, r0);
    set_reg(REG_F_ROW1, r1);
    set_reg(REG_F_ROW2, r2);
  endtask

  // Wait until every queued word is sent and scored, then let the datapath settle.
  task automatic drain();
    do @(posedge clk_i); while (pend_q.size() != 0 || in_valid || score_q.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  // input side: predict on acceptance, then present the next word or idle
  always @(posedge clk_i) begin
    if (in_valid && !in_stall_o) score_q.insert(score_q.size(), score_match(cur_match));
    if (!in_valid || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 6) begin
        send_gap = gap_len();
        in_valid <= 1'b0;
      end else if (rst_ni && pend_q.size() != 0) begin
        cur_match = pend_q.pop_front();
        x1          <= cur_match.x1;
        y1          <= cur_match.y1;
        x2          <= cur_match.x2;
        y2          <= cur_match.y2;
        match_index <= cur_match.idx;
        last_match  <= cur_match.last;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: check each accepted word, then decide the next stall
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (score_q.size() == 0) begin
        $error("result with no match pending: match_id %0d", match_id_o);
        n_errors++;
      end else begin
        want = score_q.pop_front();
        if (match_id_o !== want.match_id) begin
          $error("match_id: expected %0d, got %0d", want.match_id, match_id_o);
          n_errors++;
        end
        if (inlier_o !== want.inlier) begin
          $error("inlier: expected %0d, got %0d", want.inlier, inlier_o);
          n_errors++;
        end
        if (distance_o !== want.distance) begin
          $error("distance: expected %h, got %h", want.distance, distance_o);
          n_errors++;
        end
        if (inlier_count_o !== want.count) begin
          $error("inlier_count: expected %0d, got %0d", want.count, inlier_count_o);
          n_errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          n_errors++;
        end
      end
    end
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 99) < 6) stall_left = gap_len();
    out_stall <= (stall_left > 0);
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    line_e line;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // F at reset is all zero: zero denominator on every match
    add_pending(mk_match(-32768, 32767, 32767, -32768, 16'hFFFF, 1'b1));
    add_pending(mk_match(0, 0, 0, 0, 0, 1'b0));
    drain();

    // horizontal epipolar lines: distance is half the squared row offset
    set_f(64'd0, pack_row(0, 0, -65536), pack_row(0, 65536, 0));
    add_pending(mk_match(0, 0, 0, 0, 0, 1'b0));
    add_pending(mk_match(100, 200, -300, 192, 1, 1'b0));
    add_pending(mk_match(100, 200, -300, 209, 2, 1'b0));
    add_pending(mk_match(-32768, 32767, 32767, 32767, 16'hFFFF, 1'b0));
    add_pending(mk_match(-32768, -32768, 32767, 32767, 16'h5555, 1'b1));
    add_pending(mk_match(32767, -32768, -32768, -32768, 16'hAAAA, 1'b0));
    add_pending(mk_match(5, 7, 9, 15, 3, 1'b1));
    drain();
    // zero threshold: not even an exact match passes
    set_reg(REG_THR, 64'd0);
    add_pending(mk_match(10, 20, 30, 20, 4, 1'b1));
    drain();

    // tiny denominator against a huge residual: saturated quotient
    set_f(pack_row(0, 0, 1), 64'd0, pack_row(0, 0, 131071));
    set_reg(REG_THR, 64'hFFFF_FFFF_FFFF_FFFF);
    add_pending(mk_match(0, 0, 0, 0, 7, 1'b0));
    add_pending(mk_match(32767, 32767, -32768, 32767, 8, 1'b1));
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          set_f(64'd0, pack_row(0, 0, -65536), pack_row(0, 65536, 0));
          set_reg(REG_THR, 64'(THR_RESET));
          line = LINE_HORIZ;
        end
        1: begin
          set_f(pack_row(0, 0, 65536), 64'd0, pack_row(-65536, 0, 0));
          set_reg(REG_THR, 64'($urandom_range(0, 4000)));
          line = LINE_VERT;
        end
        2: begin
          set_f(pack_row(jitter(), jitter(), jitter()),
                pack_row(jitter(), jitter(), -65536 + jitter()),
                pack_row(jitter(), 65536 + jitter(), jitter()));
          set_reg(REG_THR, 64'($urandom_range(0, 1 << 20)));
          line = LINE_HORIZ;
        end
        3: begin
          set_f({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
          set_reg(REG_THR, {$urandom, $urandom});
          line = LINE_NONE;
        end
        4: begin
          set_f(pack_row(extreme_entry(), extreme_entry(), extreme_entry()),
                pack_row(extreme_entry(), extreme_entry(), extreme_entry()),
                pack_row(extreme_entry(), extreme_entry(), extreme_entry()));
          set_reg(REG_THR, 64'hFFFF_FFFF);
          line = LINE_NONE;
        end
        default: begin
          set_f(pack_row(jitter(), jitter(), 65536 + jitter()),
                pack_row(jitter(), jitter(), jitter()),
                pack_row(-65536 + jitter(), jitter(), jitter()));
          set_reg(REG_THR, 64'($urandom_range(0, 64)));
          line = LINE_VERT;
        end
      endcase
      // one phase runs with no idling on either side
      quiet = (p == 1);
      repeat (185) add_pending(random_match(line));
      drain();
    end

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
